// ----- rtl/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/ppe_pkg.sv -----
`default_nettype none

package ppe_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int ARGB_W     = 32;
  localparam int SLOT_W     = 8;
  localparam int CNT_W      = 25;
  localparam int COLORS_W   = 9;
  localparam int FMT_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 25;

  localparam int MOD_STEPS = 8;
  localparam int MOD_CNT_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_FORMAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_COLORS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT    = 2'd3;

  localparam logic [FMT_W-1:0] FMT_RGBA8888 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_IDX4     = 2'd1;
  localparam logic [FMT_W-1:0] FMT_IDX8     = 2'd2;
  localparam logic [FMT_W-1:0] FMT_UNSUP    = 2'd3;

  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_PIXEL   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SIZE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FORMAT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PALETTE = 2'd3;

  // output word source
  localparam logic [1:0] SRC_ERR  = 2'd0;
  localparam logic [1:0] SRC_RGBA = 2'd1;
  localparam logic [1:0] SRC_PAL  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] entry_slot;
    logic [31:0]       data_word;
  } in_word_t;

  typedef struct packed {
    logic [ARGB_W-1:0]   argb;
    logic [STATUS_W-1:0] status;
    logic                final_pixel;
    logic                last_of_run;
  } out_word_t;

  typedef struct packed {
    logic       mod_start;
    logic       mod_hi;
    logic       mod_step;
    logic       ram_rd;
    logic       out_load;
    logic [1:0] out_src;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] err;
    logic                done;
    logic                two_px;
    logic                rgba;
    logic                out_free;
  } ctrl_stat_t;

  // memory byte order R,G,B,A -> A,R,G,B
  function automatic logic [ARGB_W-1:0] reorder(input logic [31:0] w);
    return {w[31:24], w[7:0], w[15:8], w[23:16]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ppe_ram.sv -----
`default_nettype none

module ppe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppe_ctrl.sv -----
`default_nettype none

module ppe_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_cmd,
  output logic                    in_ready,
  input  wire ppe_pkg::ctrl_stat_t stat,
  output ppe_pkg::ctrl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  localparam logic [ppe_pkg::MOD_CNT_W-1:0] STEP_LAST =
    ppe_pkg::MOD_CNT_W'(ppe_pkg::MOD_STEPS - 1);

  logic [2:0]                     state, state_next;
  logic [ppe_pkg::MOD_CNT_W-1:0]  step, step_next;
  logic                           pair, pair_next;
  logic                           hi, hi_next;
  logic [1:0]                     src, src_next;
  logic                           last, last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      pair  <= 1'b0;
      hi    <= 1'b0;
      src   <= ppe_pkg::SRC_ERR;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      pair  <= pair_next;
      hi    <= hi_next;
      src   <= src_next;
      last  <= last_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    pair_next    = pair;
    hi_next      = hi;
    src_next     = src;
    last_next    = last;
    in_ready     = (state == S_IDLE);
    cmd          = '0;
    cmd.mod_hi   = hi;
    cmd.out_src  = src;
    cmd.out_last = last;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_cmd == ppe_pkg::CMD_PIXEL) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.err != ppe_pkg::ST_OK) begin
          src_next   = ppe_pkg::SRC_ERR;
          last_next  = 1'b1;
          state_next = S_EMIT;
        end else if (stat.done) begin
          state_next = S_IDLE;
        end else if (stat.rgba) begin
          src_next   = ppe_pkg::SRC_RGBA;
          last_next  = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.mod_start = 1'b1;
          cmd.mod_hi    = 1'b0;
          hi_next       = 1'b0;
          pair_next     = stat.two_px;
          step_next     = '0;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_LAST) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.ram_rd = 1'b1;
        src_next   = ppe_pkg::SRC_PAL;
        last_next  = !pair || hi;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (src == ppe_pkg::SRC_PAL && pair && !hi) begin
            // high nibble next
            hi_next       = 1'b1;
            cmd.mod_start = 1'b1;
            cmd.mod_hi    = 1'b1;
            step_next     = '0;
            state_next    = S_MOD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/ppe_datapath.sv -----
`default_nettype none

module ppe_datapath #(
  parameter int PALETTE_DEPTH = ppe_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [ppe_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  wire logic [ppe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_accept,
  input  wire ppe_pkg::in_word_t                in_data,
  input  wire ppe_pkg::ctrl_cmd_t               cmd,
  output ppe_pkg::ctrl_stat_t                   stat,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output ppe_pkg::out_word_t                    out_data
);

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [ppe_pkg::COLORS_W-1:0] DEPTH_V = ppe_pkg::COLORS_W'(PALETTE_DEPTH);

  logic [ppe_pkg::FMT_W-1:0]    pixel_format;
  logic                         palette_format;
  logic [ppe_pkg::COLORS_W-1:0] palette_colors;
  logic [ppe_pkg::CNT_W-1:0]    pixel_count;
  logic [ppe_pkg::CNT_W-1:0]    pixels_emitted;
  logic [ppe_pkg::CNT_W-1:0]    emitted_inc;
  logic [ppe_pkg::CNT_W-1:0]    remaining;

  logic [31:0]                  word_q;
  logic [ppe_pkg::COLORS_W-1:0] colors_eff;
  logic [7:0]                   quo;
  logic [ppe_pkg::COLORS_W-1:0] rem;
  logic [ppe_pkg::COLORS_W-1:0] trial;
  logic [7:0]                   mod_init;

  logic                         ram_we;
  logic [ppe_pkg::ARGB_W-1:0]   ram_rdata;
  logic [ppe_pkg::STATUS_W-1:0] err;
  logic                         out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format   <= ppe_pkg::FMT_RGBA8888;
      palette_format <= 1'b0;
      palette_colors <= '0;
      pixel_count    <= '0;
      pixels_emitted <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          ppe_pkg::REG_PIXEL_FORMAT:   pixel_format   <= cfg_wdata[ppe_pkg::FMT_W-1:0];
          ppe_pkg::REG_PALETTE_FORMAT: palette_format <= cfg_wdata[0];
          ppe_pkg::REG_PALETTE_COLORS: palette_colors <= cfg_wdata[ppe_pkg::COLORS_W-1:0];
          ppe_pkg::REG_PIXEL_COUNT: begin
            pixel_count    <= cfg_wdata[ppe_pkg::CNT_W-1:0];
            pixels_emitted <= '0;
          end
          default: ;
        endcase
      end else if (cmd.out_load && cmd.out_src != ppe_pkg::SRC_ERR) begin
        pixels_emitted <= emitted_inc;
      end
    end
  end

  assign emitted_inc = pixels_emitted + 1'b1;
  assign remaining   = pixel_count - pixels_emitted;
  assign colors_eff  = (palette_colors > DEPTH_V) ? DEPTH_V : palette_colors;

  always_comb begin
    if (pixel_count == '0) begin
      err = ppe_pkg::ST_BAD_SIZE;
    end else if (pixel_format == ppe_pkg::FMT_UNSUP ||
                 (pixel_format != ppe_pkg::FMT_RGBA8888 && palette_format)) begin
      err = ppe_pkg::ST_BAD_FORMAT;
    end else if (pixel_format != ppe_pkg::FMT_RGBA8888 && palette_colors == '0) begin
      err = ppe_pkg::ST_NO_PALETTE;
    end else begin
      err = ppe_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      word_q <= in_data.data_word;
    end
  end

  assign ram_we = in_accept && in_data.cmd == ppe_pkg::CMD_PALETTE &&
                  ({1'b0, in_data.entry_slot} < DEPTH_V);

  ppe_ram #(
    .WIDTH (ppe_pkg::ARGB_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.entry_slot[AW-1:0]),
    .wdata (ppe_pkg::reorder(in_data.data_word)),
    .re    (cmd.ram_rd),
    .raddr (rem[AW-1:0]),
    .rdata (ram_rdata)
  );

  // index mod colors, restoring remainder, one bit per cycle
  always_comb begin
    if (cmd.mod_hi) begin
      mod_init = {4'h0, word_q[7:4]};
    end else if (pixel_format == ppe_pkg::FMT_IDX4) begin
      mod_init = {4'h0, word_q[3:0]};
    end else begin
      mod_init = word_q[7:0];
    end
  end

  assign trial = {rem[7:0], quo[7]};

  always_ff @(posedge clk) begin
    if (cmd.mod_start) begin
      quo <= mod_init;
      rem <= '0;
    end else if (cmd.mod_step) begin
      quo <= {quo[6:0], 1'b0};
      rem <= (trial >= colors_eff) ? trial - colors_eff : trial;
    end
  end

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_src)
        ppe_pkg::SRC_RGBA: begin
          out_data.argb        <= ppe_pkg::reorder(word_q);
          out_data.status      <= ppe_pkg::ST_OK;
          out_data.final_pixel <= (emitted_inc == pixel_count);
          out_data.last_of_run <= cmd.out_last;
        end
        ppe_pkg::SRC_PAL: begin
          out_data.argb        <= ram_rdata;
          out_data.status      <= ppe_pkg::ST_OK;
          out_data.final_pixel <= (emitted_inc == pixel_count);
          out_data.last_of_run <= cmd.out_last;
        end
        default: begin
          out_data.argb        <= '0;
          out_data.status      <= err;
          out_data.final_pixel <= 1'b0;
          out_data.last_of_run <= 1'b1;
        end
      endcase
    end
  end

  assign stat.err      = err;
  assign stat.done     = (pixels_emitted >= pixel_count);
  assign stat.two_px   = (pixel_format == ppe_pkg::FMT_IDX4) &&
                         (remaining >= ppe_pkg::CNT_W'(2));
  assign stat.rgba     = (pixel_format == ppe_pkg::FMT_RGBA8888);
  assign stat.out_free = out_free;

endmodule

`default_nettype wire

// ----- rtl/palette_pixel_expander_core.sv -----
// Channel  Dir  Handshake          Word
// in       in   in_valid/in_ready   ppe_pkg::in_word_t (cmd, entry_slot, data_word)
// out      out  out_valid/out_ready ppe_pkg::out_word_t (argb, status, final_pixel, last_of_run)
// cfg      in   cfg_we              cfg_addr, cfg_wdata
//
// Palette write: taken on acceptance. RGBA8888 pixel or error: check, then emit.
// Indexed pixel: check, 8-step remainder unit, one registered palette read, emit.
// An indexed-4 word with two pixels left repeats remainder, read and emit for its high nibble.
// Sync reset clears config, pixel counter and control; palette is undefined until written.
// A finished word waits in the output register while the next input word is taken.
`default_nettype none
`include "assert_macros.svh"

module palette_pixel_expander_core #(
  parameter int PALETTE_DEPTH = ppe_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ppe_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [ppe_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire ppe_pkg::in_word_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output ppe_pkg::out_word_t                  out_data
);

  ppe_pkg::ctrl_cmd_t  cmd;
  ppe_pkg::ctrl_stat_t stat;
  logic                in_accept;

  assign in_accept = in_valid && in_ready;

  ppe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppe_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_accept (in_accept),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `ASSERT_IMPLIES(a_err_word, clk, rst, out_valid && out_data.status != ppe_pkg::ST_OK, out_data.last_of_run && !out_data.final_pixel && out_data.argb == '0, "error word malformed")
  `ASSERT_IMPLIES(a_final_ends_run, clk, rst, out_valid && out_data.final_pixel, out_data.last_of_run, "final pixel not last of run")
  `ASSERT_NEXT(a_pixel_busy, clk, rst, in_accept && in_data.cmd == ppe_pkg::CMD_PIXEL, !in_ready, "ready after pixel word")

endmodule

`default_nettype wire
